// ===== sv/tsb_pkg.sv =====
package tsb_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIME_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int HANDLE_W  = 4;
  localparam int FIRED_W   = 3;
  localparam int KIND_W    = 2;
  localparam int HCMP_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 3'd0,
    FUNC_CREATE   = 3'd1,
    FUNC_DELETE   = 3'd2,
    FUNC_ONESHOT  = 3'd3,
    FUNC_PERIODIC = 3'd4,
    FUNC_SETDLY   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_SPENT    = 2'd1,
    MODE_ONESHOT  = 2'd2,
    MODE_PERIODIC = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_FIRED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HANDLE,
    S_FINISH
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIME_W-1:0]  deadline;
    logic [TIME_W-1:0]  period;
  } slot_entry_t;

  localparam slot_entry_t ENTRY_RESET = '{mode: MODE_FREE, deadline: '1, period: '0};

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } slot_rd_t;

  typedef struct packed {
    logic              en;
    logic              clr;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } slot_wr_t;

endpackage

// ===== sv/tsb_if.sv =====
interface tsb_in_if;
  logic                            valid;
  logic                            ready;
  logic [tsb_pkg::FUNC_W-1:0]      func;
  logic [tsb_pkg::HANDLE_W-1:0]    slot_handle;
  logic [tsb_pkg::TIME_W-1:0]      delay_ticks;
  logic                            repeat_mode;

  modport source (output valid, func, slot_handle, delay_ticks, repeat_mode, input ready);
  modport sink   (input valid, func, slot_handle, delay_ticks, repeat_mode, output ready);
endinterface

interface tsb_out_if;
  logic                            valid;
  logic                            ready;
  logic [tsb_pkg::KIND_W-1:0]      result_kind;
  logic [tsb_pkg::HANDLE_W-1:0]    new_handle;
  logic [tsb_pkg::FIRED_W-1:0]     fired_slot;
  logic                            last;

  modport source (output valid, result_kind, new_handle, fired_slot, last, input ready);
  modport sink   (input valid, result_kind, new_handle, fired_slot, last, output ready);
endinterface

// ===== sv/tsb_slot_mem.sv =====
module tsb_slot_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tsb_pkg::slot_rd_t      rd,
  output tsb_pkg::slot_entry_t   rd_data,
  input  tsb_pkg::slot_wr_t      wr
);

  tsb_pkg::slot_entry_t mem [tsb_pkg::NUM_SLOTS];
  logic [tsb_pkg::NUM_SLOTS-1:0] valid_r;
  tsb_pkg::slot_entry_t          rd_q_r;
  logic                          rd_v_r;

  // unwritten or deleted entries read as the reset entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= !wr.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.clr) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
      rd_v_r <= valid_r[rd.addr];
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : tsb_pkg::ENTRY_RESET;

endmodule

// ===== sv/timer_slot_bank.sv =====
// Bank of NUM_SLOTS timers held in a one-port-read, one-port-write slot memory. A tick
// steps through accept, one memory entry per cycle and a final result, and a create
// stops at the first free slot or the last slot, since both walk the memory from slot 0 one entry a cycle;
// every other operation is an accept and then an acknowledge, ignored ones included. A
// result register parts the output; a stalled output holds the walk. Results of a tick
// come in slot order, last set on the final one; a tick with no expiry gives one acknowledge.
module timer_slot_bank (
  input  logic       clk,
  input  logic       rst_n,
  tsb_in_if.sink     in_chan,
  tsb_out_if.source  out_chan
);

  tsb_pkg::state_t                  state_r, state_nxt;
  logic [tsb_pkg::SLOT_W-1:0]       idx_r, idx_nxt;
  logic [tsb_pkg::TIME_W-1:0]       tick_r, tick_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [tsb_pkg::SLOT_W-1:0]       pend_slot_r, pend_slot_nxt;

  tsb_pkg::func_t                   func_r;
  logic [tsb_pkg::SLOT_W-1:0]       hidx_r;
  logic [tsb_pkg::TIME_W-1:0]       delay_r;
  logic                             rep_r;

  logic                             out_valid_r;
  tsb_pkg::kind_t                   out_kind_r;
  logic [tsb_pkg::HANDLE_W-1:0]     out_handle_r;
  logic [tsb_pkg::FIRED_W-1:0]      out_slot_r;
  logic                             out_last_r;

  logic                             push;
  tsb_pkg::kind_t                   push_kind;
  logic [tsb_pkg::HANDLE_W-1:0]     push_handle;
  logic [tsb_pkg::FIRED_W-1:0]      push_slot;
  logic                             push_last;

  tsb_pkg::slot_rd_t                rd;
  tsb_pkg::slot_wr_t                wr;
  tsb_pkg::slot_entry_t             ent;

  logic                             accept;
  logic                             out_free;
  logic                             idx_last;
  logic                             active;
  logic                             hit;
  logic                             is_hop;
  logic                             handle_ok;
  logic [tsb_pkg::SLOT_W-1:0]       in_hidx;

  tsb_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .rd_data (ent),
    .wr      (wr)
  );

  assign in_chan.ready = (state_r == tsb_pkg::S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign idx_last      = (idx_r == tsb_pkg::SLOT_W'(tsb_pkg::NUM_SLOTS - 1));
  assign active        = (ent.mode == tsb_pkg::MODE_ONESHOT) ||
                         (ent.mode == tsb_pkg::MODE_PERIODIC);
  assign hit           = active && (ent.deadline == tick_r);

  assign is_hop    = (in_chan.func == tsb_pkg::FUNC_DELETE)   ||
                     (in_chan.func == tsb_pkg::FUNC_ONESHOT)  ||
                     (in_chan.func == tsb_pkg::FUNC_PERIODIC) ||
                     (in_chan.func == tsb_pkg::FUNC_SETDLY);
  assign handle_ok = (in_chan.slot_handle != '0) &&
                     (tsb_pkg::HCMP_W'(in_chan.slot_handle) <=
                      tsb_pkg::HCMP_W'(tsb_pkg::NUM_SLOTS));
  assign in_hidx   = tsb_pkg::SLOT_W'(tsb_pkg::HCMP_W'(in_chan.slot_handle) -
                                      tsb_pkg::HCMP_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsb_pkg::S_IDLE;
      tick_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (accept) begin
      func_r  <= tsb_pkg::func_t'(in_chan.func);
      hidx_r  <= in_hidx;
      delay_r <= in_chan.delay_ticks;
      rep_r   <= in_chan.repeat_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r   <= push_kind;
      out_handle_r <= push_handle;
      out_slot_r   <= push_slot;
      out_last_r   <= push_last;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    rd            = '0;
    wr            = '0;
    wr.addr       = idx_r;
    wr.data       = ent;
    push          = 1'b0;
    push_kind     = tsb_pkg::KIND_ACK;
    push_handle   = '0;
    push_slot     = '0;
    push_last     = 1'b1;

    unique case (state_r)
      tsb_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          priority if (in_chan.func == tsb_pkg::FUNC_TICK) begin
            tick_nxt   = tick_r + tsb_pkg::TIME_W'(1);
            rd.en      = 1'b1;
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = tsb_pkg::S_SCAN;
          end else if (in_chan.func == tsb_pkg::FUNC_CREATE) begin
            rd.en     = 1'b1;
            idx_nxt   = '0;
            state_nxt = tsb_pkg::S_SCAN;
          end else if (is_hop && handle_ok) begin
            rd.en     = 1'b1;
            rd.addr   = in_hidx;
            state_nxt = tsb_pkg::S_HANDLE;
          end else begin
            // ignored operation: only its acknowledge is owed
            state_nxt = tsb_pkg::S_FINISH;
            pend_v_nxt = 1'b0;
          end
        end
      end

      tsb_pkg::S_SCAN: begin
        if (func_r == tsb_pkg::FUNC_TICK) begin
          if (!(hit && pend_v_r) || out_free) begin
            if (hit) begin
              wr.en = 1'b1;
              if (ent.mode == tsb_pkg::MODE_ONESHOT) begin
                wr.data.mode = tsb_pkg::MODE_SPENT;
              end else begin
                wr.data.deadline = tick_r + ent.period;
              end
              if (pend_v_r) begin
                push      = 1'b1;
                push_kind = tsb_pkg::KIND_FIRED;
                push_slot = tsb_pkg::FIRED_W'(pend_slot_r);
                push_last = 1'b0;
              end
              pend_v_nxt    = 1'b1;
              pend_slot_nxt = idx_r;
            end
            if (idx_last) begin
              state_nxt = tsb_pkg::S_FINISH;
            end else begin
              rd.en   = 1'b1;
              rd.addr = idx_r + tsb_pkg::SLOT_W'(1);
              idx_nxt = idx_r + tsb_pkg::SLOT_W'(1);
            end
          end
        end else begin
          if (ent.mode == tsb_pkg::MODE_FREE) begin
            if (out_free) begin
              wr.en            = 1'b1;
              wr.data.mode     = rep_r ? tsb_pkg::MODE_PERIODIC : tsb_pkg::MODE_ONESHOT;
              wr.data.deadline = tick_r + delay_r;
              wr.data.period   = delay_r;
              push             = 1'b1;
              push_kind        = tsb_pkg::KIND_CREATE;
              push_handle      = tsb_pkg::HANDLE_W'(idx_r) + tsb_pkg::HANDLE_W'(1);
              state_nxt        = tsb_pkg::S_IDLE;
            end
          end else if (idx_last) begin
            if (out_free) begin
              push      = 1'b1;
              push_kind = tsb_pkg::KIND_CREATE;
              state_nxt = tsb_pkg::S_IDLE;
            end
          end else begin
            rd.en   = 1'b1;
            rd.addr = idx_r + tsb_pkg::SLOT_W'(1);
            idx_nxt = idx_r + tsb_pkg::SLOT_W'(1);
          end
        end
      end

      tsb_pkg::S_HANDLE: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = tsb_pkg::S_IDLE;
          wr.addr   = hidx_r;
          if (ent.mode != tsb_pkg::MODE_FREE) begin
            wr.en = 1'b1;
            unique case (func_r)
              tsb_pkg::FUNC_DELETE:   wr.clr = 1'b1;
              tsb_pkg::FUNC_ONESHOT:  wr.data.mode = tsb_pkg::MODE_ONESHOT;
              tsb_pkg::FUNC_PERIODIC: wr.data.mode = tsb_pkg::MODE_PERIODIC;
              default:                wr.data.period = delay_r;
            endcase
          end
        end
      end

      tsb_pkg::S_FINISH: begin
        if (out_free) begin
          push       = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = tsb_pkg::S_IDLE;
          if (pend_v_r) begin
            push_kind = tsb_pkg::KIND_FIRED;
            push_slot = tsb_pkg::FIRED_W'(pend_slot_r);
          end
        end
      end

      default: begin
        state_nxt = tsb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.new_handle  = out_handle_r;
  assign out_chan.fired_slot  = out_slot_r;
  assign out_chan.last        = out_last_r;

  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.func == tsb_pkg::FUNC_TICK)) |=>
      (tick_r == $past(tick_r) + tsb_pkg::TIME_W'(1)))
    else $error("tick counter did not advance on tick");

  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r != tsb_pkg::S_IDLE))
    else $error("slot memory written while idle");

  a_pend_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_v_r && (state_r == tsb_pkg::S_SCAN)) |-> (pend_slot_r < idx_r))
    else $error("pending fired slot not below scan index");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result overwrote an untaken result");

endmodule
